// ===== design/msspg_pkg.sv =====
// ----------------------------------------------------------------------------
// msspg_pkg
// shared types and constants of the multi-axis step pulse generator
// ----------------------------------------------------------------------------
package msspg_pkg;

    localparam int NUM_AXES    = 3;
    localparam int MASK_W      = 3;
    localparam int CMD_W       = 2;
    localparam int AXIS_W      = 2;
    localparam int VALUE_W     = 32;
    localparam int TICK_RATE_W = 20;
    localparam int PHASE_W     = 21;

    localparam logic [TICK_RATE_W-1:0] TICK_RATE_RESET = 20'd20000;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RATE_WR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_POS = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [AXIS_W-1:0]         axis;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [MASK_W-1:0]         step_mask;
        logic [MASK_W-1:0]         dir_mask;
        logic signed [VALUE_W-1:0] axis_position;
    } out_item_t;

    // per-axis control, already qualified by the processing strobe
    typedef struct packed {
        logic                   tick;
        logic                   rate_wr;
        logic                   load_pos;
        logic [VALUE_W-1:0]     value;
        logic [TICK_RATE_W-1:0] tick_rate;
    } axis_ctrl_t;

    typedef struct packed {
        logic [VALUE_W-1:0] position;
        logic               step_high;
        logic               forward;
    } axis_state_t;

endpackage

// ===== design/msspg_axis.sv =====
// ----------------------------------------------------------------------------
// msspg_axis
// one dda axis: rate, phase accumulator, step level, direction and position
// ----------------------------------------------------------------------------
module msspg_axis
    import msspg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  axis_ctrl_t  ctrl,
    output axis_state_t state,
    output axis_state_t state_next
);

    logic [VALUE_W-1:0] rate_reg;
    logic [VALUE_W-1:0] rate_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    axis_state_t        st_reg;

    logic                   neg;
    logic [VALUE_W-1:0]     mag_full;
    logic [TICK_RATE_W-1:0] mag;
    logic [PHASE_W-1:0]     phase_sum;
    logic [PHASE_W-1:0]     tick_rate_ext;

    assign neg           = rate_reg[VALUE_W-1];
    assign mag_full      = neg ? (VALUE_W'(0) - rate_reg) : rate_reg;
    assign mag           = (mag_full > VALUE_W'(ctrl.tick_rate)) ? ctrl.tick_rate
                                                                 : mag_full[TICK_RATE_W-1:0];
    assign tick_rate_ext = PHASE_W'(ctrl.tick_rate);
    assign phase_sum     = phase_reg + PHASE_W'(mag);

    always_comb
    begin
        rate_next  = rate_reg;
        phase_next = phase_reg;
        state_next = st_reg;
        if (ctrl.rate_wr)
        begin
            rate_next = ctrl.value;
        end
        if (ctrl.load_pos)
        begin
            state_next.position = ctrl.value;
        end
        if (ctrl.tick)
        begin
            if (st_reg.step_high)
            begin
                state_next.step_high = 1'b0;
            end
            else if (rate_reg != '0)
            begin
                phase_next = phase_sum;
                if (phase_sum >= tick_rate_ext)
                begin
                    phase_next           = phase_sum - tick_rate_ext;
                    state_next.forward   = ~neg;
                    state_next.step_high = 1'b1;
                    state_next.position  = neg ? (st_reg.position - VALUE_W'(1))
                                               : (st_reg.position + VALUE_W'(1));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg          <= '0;
            phase_reg         <= '0;
            st_reg.position   <= '0;
            st_reg.step_high  <= 1'b0;
            st_reg.forward    <= 1'b1;
        end
        else
        begin
            rate_reg  <= rate_next;
            phase_reg <= phase_next;
            st_reg    <= state_next;
        end
    end

    assign state = st_reg;

endmodule

// ===== design/multi_axis_step_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// multi_axis_step_pulse_generator
// dda step pulse generator for several axes driven by tick, rate and load beats
// ----------------------------------------------------------------------------
// Each input beat is a tick, a set-rate for one axis or a position load for
// one axis, and each produces exactly one output beat with the step and
// direction masks and the position of the named axis. A beat is registered at
// the input, processed by all axes in parallel and written to the output
// register, so the block takes one beat per clock and each result is driven
// from the output register once the axes have processed it. The
// only thing that slows the rate is out_stall: while the output beat is held,
// at most one more beat waits in the input register and in_stall rises. A step
// pulse lasts exactly one tick; the tick after a step always clears it.
// tick_rate is written through the cfg channel, which is always ready, and
// must only be changed while no beat is in flight.
module multi_axis_step_pulse_generator
    import msspg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input beats
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    // output beats
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data,
    // tick_rate register
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [TICK_RATE_W-1:0] cfg_data
);

    // input register
    logic     in_vld_reg;
    in_item_t in_reg;

    // output register
    logic      out_vld_reg;
    out_item_t out_reg;
    out_item_t out_next;

    logic [TICK_RATE_W-1:0] tick_rate_reg;

    logic advance;
    logic fire;
    logic in_take;

    axis_ctrl_t  ctrl     [NUM_AXES];
    axis_state_t st_cur   [NUM_AXES];
    axis_state_t st_nxt   [NUM_AXES];

    // the processing stage moves whenever the output register is free or drains
    assign advance  = !out_vld_reg || !out_stall;
    assign fire     = in_vld_reg && advance;
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign cfg_ready = 1'b1;

    // per-axis control, qualified by the processing strobe
    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        assign ctrl[a].tick      = fire && (in_reg.cmd == CMD_TICK);
        assign ctrl[a].rate_wr   = fire && (in_reg.cmd == CMD_RATE_WR)
                                   && (in_reg.axis == AXIS_W'(a));
        assign ctrl[a].load_pos  = fire && (in_reg.cmd == CMD_LOAD_POS)
                                   && (in_reg.axis == AXIS_W'(a));
        assign ctrl[a].value     = in_reg.value;
        assign ctrl[a].tick_rate = tick_rate_reg;

        msspg_axis u_axis (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl[a]),
            .state      (st_cur[a]),
            .state_next (st_nxt[a])
        );
    end

    // result from the post-item state; an axis number beyond the last reports 0
    always_comb
    begin
        out_next = '0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (a < MASK_W)
            begin
                out_next.step_mask[a] = st_nxt[a].step_high;
                out_next.dir_mask[a]  = st_nxt[a].forward;
            end
            if (in_reg.axis == AXIS_W'(a))
            begin
                out_next.axis_position = st_nxt[a].position;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            tick_rate_reg <= TICK_RATE_RESET;
        end
        else
        begin
            if (!in_stall)
            begin
                in_vld_reg <= in_valid;
            end
            if (advance)
            begin
                out_vld_reg <= in_vld_reg;
            end
            if (cfg_valid && cfg_ready)
            begin
                tick_rate_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg <= in_data;
        end
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // a tick always clears a high step level
    a_step_drop: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (in_reg.cmd == CMD_TICK) && st_cur[0].step_high |=> !st_cur[0].step_high)
        else $error("step level of axis 0 survived a tick");

    // only ticks touch step levels
    a_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && (in_reg.cmd == CMD_TICK)) |=> $stable(st_cur[0].step_high))
        else $error("step level of axis 0 changed without a tick");

    // a rising step always moves the position
    a_step_moves: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(st_cur[0].step_high) |-> st_cur[0].position != $past(st_cur[0].position))
        else $error("axis 0 stepped without moving");

    // a beat is only held back while one waits in the input register
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg && out_vld_reg)
        else $error("input stalled with room in the pipeline");

endmodule
